FILE: hdl/hsp_pkg.sv
// Shared types and constants for the five-point heat stencil stream core.
package hsp_pkg;

  localparam int DATA_W    = 32;
  localparam int HEAT_W    = 48;
  localparam int SUM_W     = 35;
  localparam int DIM_CFG_W = 11;
  localparam int ENERGY_W  = 15;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  localparam logic [CFG_W-1:0] ENERGY_RESET = 15'd1;
  localparam logic [DIM_CFG_W-1:0] DIM_RESET = 11'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_WIDTH  = 2'd0,
    REG_BLOCK_HEIGHT = 2'd1,
    REG_ENERGY       = 2'd2
  } cfg_reg_e;

  typedef logic signed [DATA_W-1:0] cell_t;

  // One classified cell as it travels from the front to the back.
  typedef struct packed {
    cell_t south;       // incoming cell, source boost applied
    cell_t east;        // previous row, one column to the right
    cell_t side;        // row above previous at this column, or previous row column 0
    logic  first_col;   // padded column zero
    logic  result;      // cell completes an interior result
    logic  last;        // final interior result of the pass
    logic  pass_start;  // padded cell (0,0)
  } hsp_rec_t;

  // Clamp a dimension register to the supported range [2, maxv].
  function automatic int unsigned clamp_dim(logic [DIM_CFG_W-1:0] v, int unsigned maxv);
    int unsigned r;
    r = 32'(v);
    if (r < 2) begin
      r = 2;
    end else if (r > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

FILE: hdl/heat_stencil_5pt_stream_core.sv
// Top level of the streaming five-point heat stencil core.
//
// The upstream side (s_axis) delivers the cells of one block padded with a one-cell
// halo, (block_height+2) rows of (block_width+2) cells, in raster order. Each cell is
// one request: tdata carries the signed Q16.16 value and tuser flags a heat source.
// The downstream side (m_axis) gives one request per interior cell, carrying the new
// value and the saturating running heat total of the pass; tlast marks the final
// interior cell. Cells of the first two padded rows and of the halo columns produce
// nothing downstream; every other cell completes the interior cell above it.
// A result appears once the cell directly below it was accepted and passed the read
// stage, the queue and the stencil register into the output register. The core takes
// one cell per clock cycle while the queue has room; the single write port of the
// two-row line store sets that figure, and every cell passes the store exactly once.
// Cells are classified and written into the line store at the front; a four-entry
// queue hands them to the stencil and accumulator at the back. When the receiver
// holds tready low the result waits in the output register, the back end and the queue
// fill, and only then does s_axis_tready drop. The configuration port writes block
// width, block height and source energy; write it only while no pass is in flight.
// Reset returns the registers to 16 x 16 and energy 1 and starts a fresh pass.
module heat_stencil_5pt_stream_core import hsp_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int FRAC_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,   // [31:0] cell_value
  input  logic [0:0]           s_axis_tuser,   // [0] is_source
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [79:0]          m_axis_tdata,   // [31:0] new_value, [79:32] heat_sum
  output logic                 m_axis_tlast    // last_cell
);

  logic              push, pop, q_valid;
  hsp_rec_t          push_rec, q_rec;
  logic [QCNT_W-1:0] q_count;
  cell_t             out_value;
  logic [HEAT_W-1:0] out_heat;

  hsp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cell_i   (cell_t'(s_axis_tdata)),
    .in_source_i (s_axis_tuser[0]),
    .q_count_i   (q_count),
    .push_o      (push),
    .push_rec_o  (push_rec)
  );

  hsp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .rec_o      (q_rec),
    .count_o    (q_count)
  );

  hsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_rec_i     (q_rec),
    .q_pop_o     (pop),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_value_o (out_value),
    .out_heat_o  (out_heat),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_heat, out_value};

endmodule

FILE: hdl/hsp_front.sv
// Front end: configuration, raster counters, source boost and the two-row line store.
module hsp_front import hsp_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int FRAC_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cell_t                in_cell_i,
  input  logic                 in_source_i,
  input  logic [QCNT_W-1:0]    q_count_i,
  output logic                 push_o,
  output hsp_rec_t             push_rec_o
);

  localparam int ROW_SLOTS = MAX_WIDTH + 2;
  localparam int DEPTH     = 2 * ROW_SLOTS;
  localparam int AW        = $clog2(DEPTH);
  localparam int CW        = $clog2(MAX_WIDTH + 2);
  localparam int RW        = $clog2(MAX_HEIGHT + 2);
  localparam int BW        = (((ENERGY_W + FRAC_BITS) > (DATA_W - 1)) ?
                               (ENERGY_W + FRAC_BITS) : (DATA_W - 1)) + 2;
  localparam logic signed [BW-1:0] CELL_MAX = BW'(32'sh7fffffff);

  logic [CW-1:0]       w_q, col_q, col_d;
  logic [RW-1:0]       h_q, row_q, row_d;
  logic [ENERGY_W-1:0] energy_q;

  logic          acc;
  logic [CW:0]   w_p1, col_ext, col_a;
  logic [RW:0]   h_p1, row_ext;
  logic          in_cols, boost_en, res_en;
  logic signed [BW-1:0] v_ext, v_sum;
  logic [BW-1:0] en_u;
  cell_t         south;
  logic [AW-1:0] addr_a, addr_b, addr_w;
  logic [QCNT_W:0] occ;

  cell_t    mem [DEPTH];
  cell_t    rd_a_q, rd_b_q;
  logic     s1_valid_q;
  hsp_rec_t s1_q;

  function automatic logic [AW-1:0] slot(logic parity, logic [CW:0] col);
    logic [AW-1:0] base;
    base = parity ? AW'(ROW_SLOTS) : AW'(0);
    return base + AW'(col);
  endfunction

  // The stage after the store read always moves into the queue, so it needs a free slot too.
  assign occ        = {1'b0, q_count_i} + {{QCNT_W{1'b0}}, s1_valid_q};
  assign in_ready_o = occ < (QCNT_W + 1)'(QDEPTH);
  assign acc        = in_valid_i && in_ready_o;

  assign w_p1    = {1'b0, w_q} + 1'b1;
  assign h_p1    = {1'b0, h_q} + 1'b1;
  assign col_ext = {1'b0, col_q};
  assign row_ext = {1'b0, row_q};

  assign in_cols  = (col_q != '0) && (col_ext <= {1'b0, w_q});
  assign boost_en = in_source_i && in_cols && (row_q != '0) && (row_ext <= {1'b0, h_q});
  assign res_en   = in_cols && (row_ext >= (RW + 1)'(2)) && (row_ext <= h_p1);

  always_comb begin
    v_ext = BW'(in_cell_i);
    en_u  = BW'(energy_q) << FRAC_BITS;
    v_sum = v_ext + signed'(en_u);
    if (!boost_en) begin
      south = in_cell_i;
    end else if (v_sum > CELL_MAX) begin
      south = cell_t'(CELL_MAX[DATA_W-1:0]);
    end else begin
      south = v_sum[DATA_W-1:0];
    end
  end

  // Port A reads the previous row one column ahead; port B reads the row two above at
  // this column, or column zero of the previous row at the start of a row.
  always_comb begin
    col_a = col_ext + 1'b1;
    if (col_a >= (CW + 1)'(ROW_SLOTS)) begin
      col_a = '0;
    end
    addr_a = slot(~row_q[0], col_a);
    addr_b = (col_q == '0) ? slot(~row_q[0], '0) : slot(row_q[0], col_ext);
    addr_w = slot(row_q[0], col_ext);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (col_ext >= w_p1) begin
      col_d = '0;
      row_d = (row_ext >= h_p1) ? '0 : row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q        <= CW'(clamp_dim(DIM_RESET, MAX_WIDTH));
      h_q        <= RW'(clamp_dim(DIM_RESET, MAX_HEIGHT));
      energy_q   <= ENERGY_W'(ENERGY_RESET);
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_BLOCK_WIDTH: begin
            w_q <= CW'(clamp_dim(cfg_wdata_i[DIM_CFG_W-1:0], MAX_WIDTH));
          end
          REG_BLOCK_HEIGHT: begin
            h_q <= RW'(clamp_dim(cfg_wdata_i[DIM_CFG_W-1:0], MAX_HEIGHT));
          end
          REG_ENERGY: begin
            energy_q <= cfg_wdata_i[ENERGY_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      s1_valid_q <= acc;
    end
  end

  // Reads return the contents from before this cycle's write.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_a_q       <= mem[addr_a];
      rd_b_q       <= mem[addr_b];
      mem[addr_w]  <= south;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q.south      <= south;
      s1_q.east       <= '0;
      s1_q.side       <= '0;
      s1_q.first_col  <= (col_q == '0);
      s1_q.result     <= res_en;
      s1_q.last       <= res_en && (row_ext == h_p1) && (col_q == w_q);
      s1_q.pass_start <= (row_q == '0) && (col_q == '0);
    end
  end

  always_comb begin
    push_rec_o      = s1_q;
    push_rec_o.east = rd_a_q;
    push_rec_o.side = rd_b_q;
  end
  assign push_o = s1_valid_q;

  a_stage_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (q_count_i < QCNT_W'(QDEPTH)))
    else $error("read stage holds a cell while the queue is full");

endmodule

FILE: hdl/hsp_queue.sv
// Short queue that decouples the front end from the stencil back end.
module hsp_queue import hsp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hsp_rec_t          push_rec_i,
  input  logic              pop_i,
  output logic              valid_o,
  output hsp_rec_t          rec_o,
  output logic [QCNT_W-1:0] count_o
);

  hsp_rec_t          entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_rec_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign rec_o   = entry_q[rd_ptr_q];
  assign count_o = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < QCNT_W'(QDEPTH)) || pop_i)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue read while empty");

endmodule

FILE: hdl/hsp_back.sv
// Back end: neighbor window, five-point stencil, saturating heat total and output register.
module hsp_back import hsp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  hsp_rec_t            q_rec_i,
  output logic                q_pop_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output cell_t               out_value_o,
  output logic [HEAT_W-1:0]   out_heat_o,
  output logic                out_last_o
);

  cell_t west_q, cen_q;
  logic  b1_valid_q, b1_result_q, b1_last_q, b1_clear_q;
  cell_t b1_res_q;
  logic signed [HEAT_W-1:0] heat_q, heat_d;
  logic  out_valid_q, out_last_q;
  cell_t out_value_q;
  logic [HEAT_W-1:0] out_heat_q;

  logic  b1_ready, out_free, advance;
  logic signed [SUM_W-1:0] sum;
  logic signed [HEAT_W:0]  hsum;

  assign out_free = !out_valid_q || out_ready_i;
  assign b1_ready = !b1_valid_q || out_free;
  assign q_pop_o  = q_valid_i && b1_ready;
  assign advance  = b1_valid_q && out_free;

  // (4c + n + s + e + w) / 8 with flooring; the shifted sum always fits a cell.
  assign sum = (SUM_W'(cen_q) <<< 2) + SUM_W'(west_q) + SUM_W'(q_rec_i.east)
             + SUM_W'(q_rec_i.side) + SUM_W'(q_rec_i.south);

  always_comb begin
    hsum = (HEAT_W + 1)'(heat_q) + (HEAT_W + 1)'(b1_res_q);
    if (hsum[HEAT_W] != hsum[HEAT_W-1]) begin
      heat_d = hsum[HEAT_W] ? {1'b1, {(HEAT_W - 1){1'b0}}} : {1'b0, {(HEAT_W - 1){1'b1}}};
    end else begin
      heat_d = hsum[HEAT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      heat_q      <= '0;
    end else begin
      if (b1_ready) begin
        b1_valid_q <= q_valid_i;
      end
      if (out_free) begin
        out_valid_q <= b1_valid_q && b1_result_q;
      end
      if (advance) begin
        if (b1_clear_q) begin
          heat_q <= '0;
        end else if (b1_result_q) begin
          heat_q <= heat_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      if (q_rec_i.first_col) begin
        west_q <= q_rec_i.side;
      end else begin
        west_q <= cen_q;
      end
      cen_q       <= q_rec_i.east;
      b1_res_q    <= sum[SUM_W-1:3];
      b1_result_q <= q_rec_i.result;
      b1_last_q   <= q_rec_i.last;
      b1_clear_q  <= q_rec_i.pass_start;
    end
    if (advance && b1_result_q) begin
      out_value_q <= b1_res_q;
      out_heat_q  <= heat_d;
      out_last_q  <= b1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_heat_o  = out_heat_q;
  assign out_last_o  = out_last_q;

  a_clear_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b1_valid_q && b1_clear_q) |-> !b1_result_q)
    else $error("pass start cell marked as producing a result");

  a_last_is_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b1_valid_q && b1_last_q) |-> b1_result_q)
    else $error("last flag on a cell without a result");

endmodule

FILE: tb/heat_stencil_5pt_stream_core_test.sv
// Self-checking stream testbench for the five-point heat stencil core.
module heat_stencil_5pt_stream_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hsp_pkg::*;

  // Sizes of the core as instantiated below.
  localparam int MAX_DIM    = 1024;
  localparam int FRAC       = 16;
  localparam int LINE_SLOTS = MAX_DIM + 2;

  // Saturation bounds of the boosted cell and of the running heat total.
  localparam longint CELL_TOP    = 64'sd2147483647;
  localparam longint HEAT_TOP    = (longint'(1) << 47) - 1;
  localparam longint HEAT_BOTTOM = -(longint'(1) << 47);

  // A result follows the cell below it through the read, queue, stencil and output
  // registers; trailing halo cells give nothing, so this many quiet cycles cover the pipe.
  localparam int SETTLE_CYCLES = 12;

  // Only the first few mismatches are printed; all of them are counted.
  localparam int REPORT_LIMIT = 40;

  // Random part: no new pass is started once this many cells were queued in all.
  localparam int CELL_TARGET = 1100;

  // Directed 2 x 2 block (4 x 4 padded cells): saturated neighbours, the most
  // negative value, a source boost that clips at the top of the cell range,
  // and source flags on halo cells that must be ignored.
  localparam logic [DATA_W-1:0] EDGE_VALUES [16] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
    32'h8000_0000, 32'h7FFF_0000, 32'h0000_0001, 32'h7FFF_FFFF,
    32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF
  };
  localparam logic [15:0] EDGE_SOURCES = 16'b1000_0110_0010_0001;

  // How the values of a generated pass are chosen.
  typedef enum int {
    FILL_RANDOM,   // any 32-bit pattern
    FILL_SMALL,    // values of a few units in Q16.16
    FILL_EXTREME,  // mostly the ends of the range, zero and minus one
    FILL_HOT,      // every cell at the top of the range
    FILL_COLD      // every cell at the bottom of the range, no sources
  } fill_e;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic              source;
  } cell_req_t;

  typedef struct {
    logic [DATA_W-1:0] new_value;
    logic [HEAT_W-1:0] heat_sum;
    logic              last_cell;
  } cell_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]     cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata  = '0;   // [31:0] cell_value
  logic [0:0]           s_axis_tuser  = '0;   // [0] is_source
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [79:0]          m_axis_tdata;         // [31:0] new_value, [79:32] heat_sum
  logic                 m_axis_tlast;         // last_cell

  heat_stencil_5pt_stream_core #(
    .MAX_WIDTH (MAX_DIM),
    .MAX_HEIGHT(MAX_DIM),
    .FRAC_BITS (FRAC)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the configuration registers, updated when a register is written.
  logic [DIM_CFG_W-1:0] width_reg  = DIM_RESET;
  logic [DIM_CFG_W-1:0] height_reg = DIM_RESET;
  logic [ENERGY_W-1:0]  energy_reg = ENERGY_RESET;

  // Our own copy of the stencil state: two padded rows, the padded position
  // of the next cell and the running heat total of the current pass.
  logic signed [DATA_W-1:0] line_rows [2*LINE_SLOTS];
  int unsigned col_pos  = 0;
  int unsigned row_pos  = 0;
  longint      heat_acc = 0;

  cell_req_t    pending_cells[$];    // cells waiting to be offered upstream
  cell_result_t expected_cells[$];   // new cell values not yet seen downstream

  int unsigned cells_queued    = 0;
  int unsigned cells_accepted  = 0;
  int unsigned results_checked = 0;
  int unsigned fail_count      = 0;
  int unsigned passes_run      = 0;
  int unsigned reg_writes      = 0;
  int unsigned holds_done      = 0;
  bit          sender_hold     = 1'b0;

  // Sender and receiver pacing state, each owned by its clocked block.
  cell_req_t    next_cell;
  int unsigned  burst_left = 0;
  int unsigned  gap_left   = 0;
  int unsigned  stall_left = 0;
  int unsigned  open_left  = 0;
  cell_result_t oldest_result;

  // Dimension as the core uses it: out-of-range register values are clamped.
  function automatic int unsigned used_dim(logic [DIM_CFG_W-1:0] raw);
    if (raw < 2) return 2;
    if (raw > MAX_DIM) return MAX_DIM;
    return int'(raw);
  endfunction

  function automatic int unsigned slot(int unsigned row, int unsigned col);
    return (row & 1) * LINE_SLOTS + col;
  endfunction

  // Takes one accepted cell through the stencil. When the cell lies below an
  // interior cell, the new value of that interior cell is queued as expected.
  function automatic void advance_stencil(logic [DATA_W-1:0] cell_bits, logic source_flag);
    int unsigned  w;
    int unsigned  h;
    int unsigned  r;
    int unsigned  c;
    longint       v;
    longint       total;
    cell_result_t res;
    w = used_dim(width_reg);
    h = used_dim(height_reg);
    r = row_pos;
    c = col_pos;
    v = longint'($signed(cell_bits));

    // Padded cell (0,0) opens a new pass.
    if (r == 0 && c == 0) heat_acc = 0;

    // Interior sources get the energy first; the sum clips at the top of the
    // cell range and the raised value is what the neighbours see as well.
    if (r >= 1 && r <= h && c >= 1 && c <= w && source_flag) begin
      v += longint'(energy_reg) << FRAC;
      if (v > CELL_TOP) v = CELL_TOP;
    end

    // This cell is the south neighbour of interior cell (r-1, c).
    if (r >= 2 && r <= h + 1 && c >= 1 && c <= w) begin
      total = 4 * longint'(line_rows[slot(r - 1, c)])
            + longint'(line_rows[slot(r - 1, c - 1)])
            + longint'(line_rows[slot(r - 1, c + 1)])
            + longint'(line_rows[slot(r, c)])
            + v;
      total = total >>> 3;  // floor division by eight
      heat_acc += total;
      if (heat_acc > HEAT_TOP) heat_acc = HEAT_TOP;
      else if (heat_acc < HEAT_BOTTOM) heat_acc = HEAT_BOTTOM;
      res.new_value = DATA_W'(total);
      res.heat_sum  = HEAT_W'(heat_acc);
      res.last_cell = (r == h + 1 && c == w);
      expected_cells.push_back(res);
    end

    line_rows[slot(r, c)] = DATA_W'(v);

    if (c >= w + 1) begin
      col_pos = 0;
      row_pos = (r >= h + 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  task automatic note_mismatch(string field, longint want, longint got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
    end
  endtask

  // Upstream driver. Cells are offered in bursts of random length with random
  // gaps in between; some bursts run back to back with no gap at all. A
  // request is taken at a rising edge with tvalid and tready high, and that is
  // when its effect on the expected results is worked out.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        advance_stencil(s_axis_tdata, s_axis_tuser[0]);
        cells_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_cells.size() != 0 && !sender_hold) begin
          next_cell = pending_cells.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_cell.value;
          s_axis_tuser  <= next_cell.source;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Downstream monitor. Every request taken is checked against the oldest
  // expectation; tready follows its own pattern of open stretches and stalls,
  // now and then a long stall that backs the core up into its input.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_cells.size() == 0) begin
          note_mismatch("unexpected result, new_value", 0,
                        longint'($signed(m_axis_tdata[31:0])));
        end else begin
          oldest_result = expected_cells.pop_front();
          if (m_axis_tdata[31:0] !== oldest_result.new_value) begin
            note_mismatch("new_value", longint'($signed(oldest_result.new_value)),
                          longint'($signed(m_axis_tdata[31:0])));
          end
          if (m_axis_tdata[79:32] !== oldest_result.heat_sum) begin
            note_mismatch("heat_sum", longint'($signed(oldest_result.heat_sum)),
                          longint'($signed(m_axis_tdata[79:32])));
          end
          if (m_axis_tlast !== oldest_result.last_cell) begin
            note_mismatch("last_cell", longint'(oldest_result.last_cell),
                          longint'(m_axis_tlast));
          end
          results_checked++;
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (open_left != 0) begin
          open_left--;
        end else begin
          open_left = $urandom_range(0, 30);
          case ($urandom_range(0, 7))
            0:       stall_left = $urandom_range(16, 24);
            1, 2, 3: stall_left = $urandom_range(1, 4);
            default: stall_left = 0;
          endcase
        end
      end
    end
  end

  // Register write through the configuration port; the shadow copy follows.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      REG_BLOCK_WIDTH:  width_reg  = value[DIM_CFG_W-1:0];
      REG_BLOCK_HEIGHT: height_reg = value[DIM_CFG_W-1:0];
      REG_ENERGY:       energy_reg = value[ENERGY_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every queued cell was taken and every expected result came,
  // then lets the trailing halo cells clear the pipe.
  task automatic wait_drained();
    while (cells_accepted != cells_queued || expected_cells.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Queues one complete padded pass at the current dimensions and waits for
  // it to finish. With pause_midway the sender stops halfway through the pass
  // until the core has delivered everything it owes.
  task automatic run_pass(fill_e fill, bit pause_midway);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned start;
    cell_req_t   req;
    w     = used_dim(width_reg);
    h     = used_dim(height_reg);
    total = (w + 2) * (h + 2);
    start = cells_accepted;
    for (int unsigned i = 0; i < total; i++) begin
      case (fill)
        FILL_RANDOM: begin
          req.value  = $urandom;
          req.source = ($urandom_range(0, 3) == 0);
        end
        FILL_SMALL: begin
          req.value  = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
          req.source = ($urandom_range(0, 2) == 0);
        end
        FILL_EXTREME: begin
          case ($urandom_range(0, 5))
            0:       req.value = 32'h7FFF_FFFF;
            1:       req.value = 32'h8000_0000;
            2:       req.value = 32'h0000_0000;
            3:       req.value = 32'hFFFF_FFFF;
            4:       req.value = 32'h0000_0001;
            default: req.value = $urandom;
          endcase
          req.source = $urandom_range(0, 1);
        end
        FILL_HOT: begin
          req.value  = 32'h7FFF_FFFF;
          req.source = $urandom_range(0, 1);
        end
        default: begin
          req.value  = 32'h8000_0000;
          req.source = 1'b0;
        end
      endcase
      pending_cells.push_back(req);
    end
    cells_queued += total;
    if (pause_midway) begin
      while (cells_accepted < start + total / 2) @(posedge clk_i);
      sender_hold = 1'b1;
      @(posedge clk_i);
      while (s_axis_tvalid || expected_cells.size() != 0) @(posedge clk_i);
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      sender_hold = 1'b0;
      holds_done++;
    end
    passes_run++;
    wait_drained();
  endtask

  // Stimulus sequence.
  initial begin
    int unsigned pass_count;
    bit          first_random;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration, 16 x 16 with energy 1, before any register write.
    run_pass(FILL_RANDOM, 1'b0);

    // Smallest block with the largest energy: range extremes and clipped boosts.
    write_reg(REG_BLOCK_WIDTH, 15'd2);
    write_reg(REG_BLOCK_HEIGHT, 15'd2);
    write_reg(REG_ENERGY, 15'h7FFF);
    for (int i = 0; i < 16; i++) begin
      pending_cells.push_back('{EDGE_VALUES[i], EDGE_SOURCES[i]});
    end
    cells_queued += 16;
    passes_run++;
    wait_drained();

    // Dimensions below the supported range clamp to two; no energy at all.
    write_reg(REG_BLOCK_WIDTH, 15'd1);
    write_reg(REG_BLOCK_HEIGHT, 15'd0);
    write_reg(REG_ENERGY, 15'd0);
    run_pass(FILL_EXTREME, 1'b0);

    // Random settings, mostly small blocks, one to three passes in a row so
    // that the heat total is seen to restart at each pass.
    first_random = 1'b1;
    while (cells_queued < CELL_TARGET) begin
      case ($urandom_range(0, 9))
        0:       write_reg(REG_BLOCK_WIDTH, 15'($urandom_range(0, 1)));
        1:       write_reg(REG_BLOCK_WIDTH, 15'($urandom_range(9, 20)));
        default: write_reg(REG_BLOCK_WIDTH, 15'($urandom_range(2, 8)));
      endcase
      case ($urandom_range(0, 9))
        0:       write_reg(REG_BLOCK_HEIGHT, 15'($urandom_range(0, 1)));
        1:       write_reg(REG_BLOCK_HEIGHT, 15'($urandom_range(9, 12)));
        default: write_reg(REG_BLOCK_HEIGHT, 15'($urandom_range(2, 8)));
      endcase
      case ($urandom_range(0, 3))
        0:       write_reg(REG_ENERGY, 15'd0);
        1:       write_reg(REG_ENERGY, 15'h7FFF);
        2:       write_reg(REG_ENERGY, 15'($urandom_range(1, 4)));
        default: write_reg(REG_ENERGY, 15'($urandom_range(0, 32767)));
      endcase
      pass_count = $urandom_range(1, 3);
      for (int unsigned p = 0; p < pass_count && cells_queued < CELL_TARGET; p++) begin
        run_pass(fill_e'($urandom_range(0, 4)), first_random || ($urandom_range(0, 5) == 0));
        first_random = 1'b0;
      end
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Summary: %0d passes, %0d cells sent, %0d results compared, %0d register writes.",
             passes_run, cells_accepted, results_checked, reg_writes);
    $display("Summary: %0d mid-pass sender pauses; clamped sizes and range extremes included.",
             holds_done);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run of this sequence.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still expected.", expected_cells.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/hsp_pkg.sv
hdl/hsp_front.sv
hdl/hsp_queue.sv
hdl/hsp_back.sv
hdl/heat_stencil_5pt_stream_core.sv
tb/heat_stencil_5pt_stream_core_test.sv
